// File: sv/rvt_pkg.sv
// ---------------------------------------------------------------------------
// rvt_pkg
// Shared constants for the reflection vertex transform unit: defaults,
// store layout, operation codes and field widths.
// ---------------------------------------------------------------------------
package rvt_pkg;

   localparam int COEF_SLOTS_DEF = 64;
   localparam int FRAC_BITS_DEF  = 16;

   // store layout, matrices column-major
   localparam int OFS_CLIP = 0;
   localparam int OFS_MV   = 16;
   localparam int OFS_NRM  = 32;
   localparam int OFS_INV  = 41;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_VERT = 1'b1;

   localparam int IDX_W  = 6;
   localparam int WORD_W = 32;
   localparam int DIR_W  = 18;

   // normalizer: five front stages, 31 root steps, one prep stage,
   // FRAC_BITS+1 quotient steps and the output register
   function automatic int norm_latency(input int frac);
      return frac + 39;
   endfunction

endpackage

// File: sv/rvt_ifs.sv
// ---------------------------------------------------------------------------
// rvt channel interfaces
// Request channel (coefficient load or vertex) and response channel
// (reflection direction and clip position), valid/ready handshake.
// ---------------------------------------------------------------------------
interface rvt_req_if;
   logic                               valid;
   logic                               ready;
   logic                               op;
   logic [rvt_pkg::IDX_W-1:0]          coef_index;
   logic signed [rvt_pkg::WORD_W-1:0]  coef_value;
   logic signed [rvt_pkg::WORD_W-1:0]  vert_x;
   logic signed [rvt_pkg::WORD_W-1:0]  vert_y;
   logic signed [rvt_pkg::WORD_W-1:0]  vert_z;

   modport source (output valid, op, coef_index, coef_value, vert_x, vert_y, vert_z,
                   input ready);
   modport sink   (input valid, op, coef_index, coef_value, vert_x, vert_y, vert_z,
                   output ready);
endinterface

interface rvt_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [rvt_pkg::DIR_W-1:0]   dir_x;
   logic signed [rvt_pkg::DIR_W-1:0]   dir_y;
   logic signed [rvt_pkg::DIR_W-1:0]   dir_z;
   logic signed [rvt_pkg::WORD_W-1:0]  clip_x;
   logic signed [rvt_pkg::WORD_W-1:0]  clip_y;
   logic signed [rvt_pkg::WORD_W-1:0]  clip_z;
   logic signed [rvt_pkg::WORD_W-1:0]  clip_w;

   modport source (output valid, dir_x, dir_y, dir_z, clip_x, clip_y, clip_z, clip_w,
                   input ready);
   modport sink   (input valid, dir_x, dir_y, dir_z, clip_x, clip_y, clip_z, clip_w,
                   output ready);
endinterface

// File: sv/rvt_norm.sv
// ---------------------------------------------------------------------------
// rvt_norm
// Pipelined 3-vector normalizer: pre-scale below 2^30, squared length,
// one root bit per stage, one quotient bit per stage with round to nearest.
// Short vectors pass through unchanged.
// ---------------------------------------------------------------------------
module rvt_norm #(
   parameter int IW = 51,
   parameter int F  = rvt_pkg::FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [IW-1:0] vec_in  [3],
   output logic signed [F+1:0]  vec_out [3]
);

   localparam int SW = $clog2(IW);
   localparam int DW = F + 32;
   localparam int OW = F + 2;
   localparam int DS = F + 2;
   localparam logic [30:0] EPS = 31'((2**F + 5000) / 10000);

   // front stages
   logic [IW-1:0]        abs_c [3];
   logic [IW-1:0]        max_c;
   logic signed [IW-1:0] v1_ff [3];
   logic [IW-1:0]        m1_ff;
   logic [SW-1:0]        s_c;
   logic signed [IW-1:0] v2_ff [3];
   logic [SW-1:0]        s2_ff;
   logic signed [30:0]   r3_ff [3];
   logic                 big3_ff;
   logic signed [61:0]   sq_c [3];
   logic [61:0]          sq4_ff [3];
   logic signed [30:0]   r4_ff [3];
   logic                 big4_ff;

   // root stages, index 0 holds the squared length
   logic [61:0]          sq_rem_ff  [32];
   logic [30:0]          sq_root_ff [32];
   logic signed [30:0]   sq_r_ff    [32][3];
   logic                 sq_big_ff  [32];
   logic [62:0]          sq_trial_c [32];

   // quotient stages, index 0 holds the rounded numerators
   logic [DW-1:0]        dv_rem_ff  [DS][3];
   logic [F:0]           dv_q_ff    [DS][3];
   logic [30:0]          dv_len_ff  [DS];
   logic signed [30:0]   dv_r_ff    [DS][3];
   logic                 dv_pass_ff [DS];
   logic [DW-1:0]        dv_trial_c [DS];

   logic [30:0]          len_c;
   logic [30:0]          rabs_c [3];
   logic signed [OW-1:0] out_ff [3];

   always_comb begin
      max_c = '0;
      for (int i = 0; i < 3; i++) begin
         abs_c[i] = vec_in[i][IW-1] ? (~vec_in[i] + 1'b1) : vec_in[i];
         if (abs_c[i] > max_c) begin
            max_c = abs_c[i];
         end
      end
   end

   // smallest shift that brings the largest magnitude below 2^30
   always_comb begin
      s_c = '0;
      for (int k = 30; k < IW; k++) begin
         if (m1_ff[k]) begin
            s_c = SW'(k - 29);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_c[i] = r3_ff[i] * r3_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v1_ff   <= vec_in;
         m1_ff   <= max_c;
         v2_ff   <= v1_ff;
         s2_ff   <= s_c;
         for (int i = 0; i < 3; i++) begin
            r3_ff[i]  <= 31'(v2_ff[i] >>> s2_ff);
            sq4_ff[i] <= sq_c[i][61:0];
         end
         big3_ff <= (s2_ff != '0);
         r4_ff   <= r3_ff;
         big4_ff <= big3_ff;
         sq_rem_ff[0]  <= sq4_ff[0] + sq4_ff[1] + sq4_ff[2];
         sq_root_ff[0] <= '0;
         sq_r_ff[0]    <= r4_ff;
         sq_big_ff[0]  <= big4_ff;
      end
   end

   always_comb begin
      sq_trial_c[0] = '0;
      for (int j = 1; j < 32; j++) begin
         sq_trial_c[j] = (63'(sq_root_ff[j-1]) << (32 - j)) + (63'(1) << (2 * (31 - j)));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 1; j < 32; j++) begin
            if ({1'b0, sq_rem_ff[j-1]} >= sq_trial_c[j]) begin
               sq_rem_ff[j]  <= sq_rem_ff[j-1] - sq_trial_c[j][61:0];
               sq_root_ff[j] <= sq_root_ff[j-1] | (31'(1) << (31 - j));
            end else begin
               sq_rem_ff[j]  <= sq_rem_ff[j-1];
               sq_root_ff[j] <= sq_root_ff[j-1];
            end
            sq_r_ff[j]   <= sq_r_ff[j-1];
            sq_big_ff[j] <= sq_big_ff[j-1];
         end
      end
   end

   assign len_c = sq_root_ff[31];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rabs_c[i] = sq_r_ff[31][i][30] ? (~sq_r_ff[31][i] + 1'b1) : sq_r_ff[31][i];
      end
      dv_trial_c[0] = '0;
      for (int t = 1; t < DS; t++) begin
         dv_trial_c[t] = DW'(dv_len_ff[t-1]) << (DS - 1 - t);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            dv_rem_ff[0][i] <= (DW'(rabs_c[i]) << F) + DW'(len_c >> 1);
            dv_q_ff[0][i]   <= '0;
         end
         dv_len_ff[0]  <= len_c;
         dv_r_ff[0]    <= sq_r_ff[31];
         dv_pass_ff[0] <= !sq_big_ff[31] && (len_c <= EPS);
         for (int t = 1; t < DS; t++) begin
            for (int i = 0; i < 3; i++) begin
               if (dv_rem_ff[t-1][i] >= dv_trial_c[t]) begin
                  dv_rem_ff[t][i] <= dv_rem_ff[t-1][i] - dv_trial_c[t];
                  dv_q_ff[t][i]   <= dv_q_ff[t-1][i] | ((F+1)'(1) << (DS - 1 - t));
               end else begin
                  dv_rem_ff[t][i] <= dv_rem_ff[t-1][i];
                  dv_q_ff[t][i]   <= dv_q_ff[t-1][i];
               end
            end
            dv_len_ff[t]  <= dv_len_ff[t-1];
            dv_r_ff[t]    <= dv_r_ff[t-1];
            dv_pass_ff[t] <= dv_pass_ff[t-1];
         end
         for (int i = 0; i < 3; i++) begin
            if (dv_pass_ff[DS-1]) begin
               out_ff[i] <= OW'(dv_r_ff[DS-1][i]);
            end else if (dv_r_ff[DS-1][i][30]) begin
               out_ff[i] <= -$signed({1'b0, dv_q_ff[DS-1][i]});
            end else begin
               out_ff[i] <= $signed({1'b0, dv_q_ff[DS-1][i]});
            end
         end
      end
   end

   assign vec_out = out_ff;

endmodule

// File: sv/reflection_vertex_transform_unit.sv
// ---------------------------------------------------------------------------
// reflection_vertex_transform_unit
// Per-vertex environment reflection transform in signed fixed point:
// coefficient store, clip/modelview/normal products, two normalizers,
// reflection, inverse camera mapping and a final normalizer.
// ---------------------------------------------------------------------------
//  channel   dir   port      carries
//  request   in    req_chan  op, coef_index, coef_value, vert_x/y/z
//  response  out   rsp_chan  dir_x/y/z, clip_x/y/z/w
//
//  one vertex per clock while the response is not stalled; the pipeline
//  depth is set by the root and quotient steps of the two normalizer
//  passes in series.
//  a load transfers only while no vertex sits before its last store read;
//  loads give no response.
//  synchronous reset clears the valid bits; the store is undefined until
//  written. a stalled response holds the whole pipeline in place.
// ---------------------------------------------------------------------------
module reflection_vertex_transform_unit #(
   parameter int COEF_SLOTS = rvt_pkg::COEF_SLOTS_DEF,
   parameter int FRAC_BITS  = rvt_pkg::FRAC_BITS_DEF
) (
   input logic    clock,
   input logic    reset,
   rvt_req_if.sink   req_chan,
   rvt_rsp_if.source rsp_chan
);

   localparam int F    = FRAC_BITS;
   localparam int CIW  = $clog2(COEF_SLOTS);
   localparam int PW   = 64 - F;
   localparam int VW   = 67 - F;
   localparam int OW   = F + 2;
   localparam int RW   = F + 4;
   localparam int IPW  = 36;
   localparam int WW   = 38;
   localparam int NLAT = rvt_pkg::norm_latency(F);
   localparam int NS   = 9 + 2 * NLAT;
   localparam int ZN   = 7 + NLAT;
   localparam int XW   = OW + rvt_pkg::DIR_W;
   localparam logic signed [VW-1:0] CMAX = $signed({{(VW-31){1'b0}}, {31{1'b1}}});
   localparam logic signed [VW-1:0] CMIN = -CMAX - 1;
   localparam logic signed [XW-1:0] DMAX = $signed({{(XW-17){1'b0}}, {17{1'b1}}});
   localparam logic signed [XW-1:0] DMIN = -DMAX - 1;

   logic signed [31:0]   coef_ff [COEF_SLOTS];
   logic                 en;
   logic                 zone_busy;
   logic                 accept;
   logic                 vld_ff [NS];

   logic signed [31:0]   p_ff [3];
   logic signed [63:0]   nrm_p [3][3];
   logic signed [63:0]   mv_p  [3][3];
   logic signed [63:0]   clp_p [4][3];
   logic signed [PW-1:0] nrm_ff [3][3];
   logic signed [PW-1:0] mv_ff  [3][3];
   logic signed [PW-1:0] clp_ff [4][3];
   logic signed [VW-1:0] nv_ff [3];
   logic signed [VW-1:0] ev_ff [3];
   logic signed [VW-1:0] acc_c [4];
   logic signed [31:0]   clip_dl_ff [NS-2][4];

   logic signed [OW-1:0] n_w [3];
   logic signed [OW-1:0] e_w [3];
   logic signed [OW-1:0] n3_ff [3];
   logic signed [OW-1:0] n4_ff [3];
   logic signed [OW-1:0] e3_ff [3];
   logic signed [OW-1:0] e4_ff [3];
   logic signed [OW-1:0] e5_ff [3];
   logic signed [2*OW-1:0] dp_p [3];
   logic signed [OW-1:0] dp_ff [3];
   logic signed [RW-1:0] d_ff;
   logic signed [RW+OW-1:0] dn_p [3];
   logic signed [RW-1:0] dn_ff [3];
   logic signed [RW-1:0] rf_ff [3];
   logic signed [RW+31:0] iv_p [3][3];
   logic signed [IPW-1:0] iv_ff [3][3];
   logic signed [WW-1:0] wv_ff [3];
   logic signed [OW-1:0] w_w [3];
   logic signed [XW-1:0] wx_c [3];
   logic signed [17:0]   dir_c [3];

   logic                 rsp_valid_ff;
   logic signed [17:0]   dir_ff  [3];
   logic signed [31:0]   clip_ff [4];

   assign en = !rsp_valid_ff || rsp_chan.ready;

   // a load waits until no vertex ahead of it still reads the store
   always_comb begin
      zone_busy = 1'b0;
      for (int k = 0; k <= ZN; k++) begin
         zone_busy = zone_busy | vld_ff[k];
      end
   end

   assign req_chan.ready = en && ((req_chan.op == rvt_pkg::OP_VERT) || !zone_busy);
   assign accept         = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (accept && (req_chan.op == rvt_pkg::OP_LOAD) &&
          ({1'b0, req_chan.coef_index} < 7'(COEF_SLOTS))) begin
         coef_ff[req_chan.coef_index[CIW-1:0]] <= req_chan.coef_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NS; k++) begin
            vld_ff[k] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= accept && (req_chan.op == rvt_pkg::OP_VERT);
         for (int k = 1; k < NS; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
         rsp_valid_ff <= vld_ff[NS-1];
      end
   end

   // first products
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int c = 0; c < 3; c++) begin
            nrm_p[i][c] = coef_ff[rvt_pkg::OFS_NRM + 3*c + i] * p_ff[c];
            mv_p[i][c]  = coef_ff[rvt_pkg::OFS_MV + 4*c + i] * p_ff[c];
         end
      end
      for (int i = 0; i < 4; i++) begin
         for (int c = 0; c < 3; c++) begin
            clp_p[i][c] = coef_ff[rvt_pkg::OFS_CLIP + 4*c + i] * p_ff[c];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         acc_c[i] = VW'(coef_ff[rvt_pkg::OFS_CLIP + 12 + i]) + VW'(clp_ff[i][0])
                  + VW'(clp_ff[i][1]) + VW'(clp_ff[i][2]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff[0] <= req_chan.vert_x;
         p_ff[1] <= req_chan.vert_y;
         p_ff[2] <= req_chan.vert_z;
         for (int i = 0; i < 3; i++) begin
            for (int c = 0; c < 3; c++) begin
               nrm_ff[i][c] <= PW'(nrm_p[i][c] >>> F);
               mv_ff[i][c]  <= PW'(mv_p[i][c] >>> F);
            end
            nv_ff[i] <= VW'(nrm_ff[i][0]) + VW'(nrm_ff[i][1]) + VW'(nrm_ff[i][2]);
            ev_ff[i] <= VW'(coef_ff[rvt_pkg::OFS_MV + 12 + i]) + VW'(mv_ff[i][0])
                      + VW'(mv_ff[i][1]) + VW'(mv_ff[i][2]);
         end
         for (int i = 0; i < 4; i++) begin
            for (int c = 0; c < 3; c++) begin
               clp_ff[i][c] <= PW'(clp_p[i][c] >>> F);
            end
            if (acc_c[i] > CMAX) begin
               clip_dl_ff[0][i] <= 32'(CMAX);
            end else if (acc_c[i] < CMIN) begin
               clip_dl_ff[0][i] <= 32'(CMIN);
            end else begin
               clip_dl_ff[0][i] <= 32'(acc_c[i]);
            end
         end
         for (int k = 1; k < NS - 2; k++) begin
            clip_dl_ff[k] <= clip_dl_ff[k-1];
         end
      end
   end

   rvt_norm #(.IW(VW), .F(F)) u_norm_n (
      .clock   (clock),
      .en      (en),
      .vec_in  (nv_ff),
      .vec_out (n_w)
   );

   rvt_norm #(.IW(VW), .F(F)) u_norm_e (
      .clock   (clock),
      .en      (en),
      .vec_in  (ev_ff),
      .vec_out (e_w)
   );

   // reflection and inverse camera mapping
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dp_p[i] = e_w[i] * n_w[i];
         dn_p[i] = d_ff * n4_ff[i];
         for (int c = 0; c < 3; c++) begin
            iv_p[i][c] = coef_ff[rvt_pkg::OFS_INV + 4*c + i] * rf_ff[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n3_ff <= n_w;
         n4_ff <= n3_ff;
         e3_ff <= e_w;
         e4_ff <= e3_ff;
         e5_ff <= e4_ff;
         for (int i = 0; i < 3; i++) begin
            dp_ff[i] <= OW'(dp_p[i] >>> F);
            dn_ff[i] <= RW'(dn_p[i] >>> F);
            rf_ff[i] <= RW'(e5_ff[i]) - dn_ff[i];
            for (int c = 0; c < 3; c++) begin
               iv_ff[i][c] <= IPW'(iv_p[i][c] >>> F);
            end
            wv_ff[i] <= WW'(coef_ff[rvt_pkg::OFS_INV + 12 + i]) + WW'(iv_ff[i][0])
                      + WW'(iv_ff[i][1]) + WW'(iv_ff[i][2]);
         end
         d_ff <= (RW'(dp_ff[0]) + RW'(dp_ff[1]) + RW'(dp_ff[2])) <<< 1;
      end
   end

   rvt_norm #(.IW(WW), .F(F)) u_norm_w (
      .clock   (clock),
      .en      (en),
      .vec_in  (wv_ff),
      .vec_out (w_w)
   );

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         wx_c[i] = XW'(w_w[i]);
         if (wx_c[i] > DMAX) begin
            dir_c[i] = 18'(DMAX);
         end else if (wx_c[i] < DMIN) begin
            dir_c[i] = 18'(DMIN);
         end else begin
            dir_c[i] = 18'(wx_c[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dir_ff  <= dir_c;
         clip_ff <= clip_dl_ff[NS-3];
      end
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.dir_x  = dir_ff[0];
   assign rsp_chan.dir_y  = dir_ff[1];
   assign rsp_chan.dir_z  = dir_ff[2];
   assign rsp_chan.clip_x = clip_ff[0];
   assign rsp_chan.clip_y = clip_ff[1];
   assign rsp_chan.clip_z = clip_ff[2];
   assign rsp_chan.clip_w = clip_ff[3];

endmodule

// File: verif/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the reflection vertex transform unit: loads the
// coefficient store, streams vertices with random gaps and stalls, and
// compares every response with an in-bench fixed-point prediction.
// ---------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC     = rvt_pkg::FRAC_BITS_DEF;
   localparam int LATENCY  = 2 * FRAC + 87;
   localparam longint ONE  = 64'sd1 <<< FRAC;
   localparam longint EPS  = (ONE + 5000) / 10000;
   localparam int LIMIT    = 600000;

   typedef struct packed {
      logic signed [rvt_pkg::DIR_W-1:0]  dx, dy, dz;
      logic signed [rvt_pkg::WORD_W-1:0] cx, cy, cz, cw;
   } shade_type;

   logic clock = 0, reset = 1;
   rvt_req_if req_chan ();
   rvt_rsp_if rsp_chan ();

   reflection_vertex_transform_unit dut (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source)
   );

   longint    coef_mem [0:rvt_pkg::COEF_SLOTS_DEF-1];
   shade_type shade_q [$];
   int     err_cnt = 0, vert_cnt = 0, load_cnt = 0, rsp_cnt = 0, cycle_cnt = 0;
   bit     hold_off = 0, rnd_stall = 1;

   initial forever #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt > LIMIT) begin
         $display("timeout after %0d cycles", cycle_cnt);
         $display("reflection_vertex_transform_unit test failed");
         $finish;
      end
   end

   function automatic longint fshift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint fmul(longint a, longint b);
      return (a * b) >>> FRAC;
   endfunction

   function automatic longint int_sqrt(longint x);
      longint res = 0, bitv = 64'sd1 <<< 62;
      while (bitv > x) bitv = bitv >>> 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x = x - (res + bitv);
            res = (res >>> 1) + bitv;
         end else begin
            res = res >>> 1;
         end
         bitv = bitv >>> 2;
      end
      return res;
   endfunction

   function automatic longint round_div(longint num, longint den);
      if (num < 0) return -((-num + den / 2) / den);
      return (num + den / 2) / den;
   endfunction

   task automatic unit_vec(input longint v[3], output longint o[3]);
      longint m = 0, a, sum = 0, len;
      longint r[3];
      int s = 0;
      for (int i = 0; i < 3; i++) begin
         a = v[i] < 0 ? -v[i] : v[i];
         if (a > m) m = a;
      end
      while ((m >> s) >= (64'sd1 <<< 30)) s++;
      for (int i = 0; i < 3; i++) begin
         r[i] = fshift(v[i], s);
         sum += r[i] * r[i];
      end
      len = int_sqrt(sum);
      for (int i = 0; i < 3; i++)
         o[i] = (s > 0 || len > EPS) ? round_div(r[i] * ONE, len) : v[i];
   endtask

   function automatic longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   task automatic predict_shade(input logic signed [31:0] px, py, pz);
      longint p[3], nv[3], n[3], ev[3], e[3], rf[3], wv[3], w[3], d, acc;
      longint cl[4];
      shade_type s;
      p[0] = px; p[1] = py; p[2] = pz;
      for (int i = 0; i < 3; i++) begin
         nv[i] = 0;
         ev[i] = coef_mem[rvt_pkg::OFS_MV + 12 + i];
         for (int c = 0; c < 3; c++) begin
            nv[i] += fmul(coef_mem[rvt_pkg::OFS_NRM + 3 * c + i], p[c]);
            ev[i] += fmul(coef_mem[rvt_pkg::OFS_MV + 4 * c + i], p[c]);
         end
      end
      unit_vec(nv, n);
      unit_vec(ev, e);
      d = 0;
      for (int i = 0; i < 3; i++) d += fmul(e[i], n[i]);
      d = d * 2;
      for (int i = 0; i < 3; i++) rf[i] = e[i] - fmul(d, n[i]);
      for (int i = 0; i < 3; i++) begin
         wv[i] = coef_mem[rvt_pkg::OFS_INV + 12 + i];
         for (int c = 0; c < 3; c++)
            wv[i] += fmul(coef_mem[rvt_pkg::OFS_INV + 4 * c + i], rf[c]);
      end
      unit_vec(wv, w);
      for (int i = 0; i < 4; i++) begin
         acc = coef_mem[rvt_pkg::OFS_CLIP + 12 + i];
         for (int c = 0; c < 3; c++)
            acc += fmul(coef_mem[rvt_pkg::OFS_CLIP + 4 * c + i], p[c]);
         cl[i] = clamp(acc, -64'sd2147483648, 64'sd2147483647);
      end
      s.dx = 18'(clamp(w[0], -131072, 131071));
      s.dy = 18'(clamp(w[1], -131072, 131071));
      s.dz = 18'(clamp(w[2], -131072, 131071));
      s.cx = 32'(cl[0]); s.cy = 32'(cl[1]); s.cz = 32'(cl[2]); s.cw = 32'(cl[3]);
      shade_q = {shade_q, s};
   endtask

   task automatic report(input string what, input longint got, input longint want);
      err_cnt++;
      $display("mismatch on %s: got %0d expected %0d (response %0d)", what, got, want, rsp_cnt);
   endtask

   // response side: random stalls, long hold-off on request
   initial begin
      int gap;
      rsp_chan.ready = 0;
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_chan.ready <= 0;
         end else if (rnd_stall && rsp_chan.ready) begin
            gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 19) : 0;
            if (gap > 0) begin
               rsp_chan.ready <= 0;
               repeat (gap) @(negedge clock);
            end
            rsp_chan.ready <= 1;
         end else begin
            rsp_chan.ready <= 1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         shade_type w;
         if (shade_q.size() == 0) begin
            report("unexpected response", 1, 0);
         end else begin
            w = shade_q.pop_front();
            if (rsp_chan.dir_x !== w.dx) report("dir_x", rsp_chan.dir_x, w.dx);
            if (rsp_chan.dir_y !== w.dy) report("dir_y", rsp_chan.dir_y, w.dy);
            if (rsp_chan.dir_z !== w.dz) report("dir_z", rsp_chan.dir_z, w.dz);
            if (rsp_chan.clip_x !== w.cx) report("clip_x", rsp_chan.clip_x, w.cx);
            if (rsp_chan.clip_y !== w.cy) report("clip_y", rsp_chan.clip_y, w.cy);
            if (rsp_chan.clip_z !== w.cz) report("clip_z", rsp_chan.clip_z, w.cz);
            if (rsp_chan.clip_w !== w.cw) report("clip_w", rsp_chan.clip_w, w.cw);
         end
         rsp_cnt++;
      end
   end

   // one transfer on the request channel, prediction at acceptance
   task automatic send_item(input logic op, input logic [5:0] idx, input logic signed [31:0] val,
                            input logic signed [31:0] x, y, z, input int gap);
      if (gap > 0) begin
         req_chan.valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid      <= 1;
      req_chan.op         <= op;
      req_chan.coef_index <= idx;
      req_chan.coef_value <= val;
      req_chan.vert_x     <= x;
      req_chan.vert_y     <= y;
      req_chan.vert_z     <= z;
      do @(posedge clock); while (!req_chan.ready);
      if (op == rvt_pkg::OP_LOAD) begin
         if (idx < rvt_pkg::COEF_SLOTS_DEF) coef_mem[idx] = val;
         load_cnt++;
      end else begin
         predict_shade(x, y, z);
         vert_cnt++;
      end
      @(negedge clock);
   endtask

   task automatic end_burst();
      req_chan.valid <= 0;
   endtask

   function automatic logic signed [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return 0;
         3: return $urandom;
         default: return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
      endcase
   endfunction

   function automatic int rand_gap();
      return $urandom_range(0, 2) == 0 ? $urandom_range(0, 19) : 0;
   endfunction

   // loads one matrix set; diag/small values keep paths in range, mode 2 is wild
   task automatic load_store(input int mode);
      logic signed [31:0] v;
      for (int i = 0; i < 57; i++) begin
         case (mode)
            0: v = ((i < 16 && i % 5 == 0) || (i >= 16 && i < 32 && (i - 16) % 5 == 0) ||
                    (i >= 41 && (i - 41) % 5 == 0) || (i >= 32 && i < 41 && (i - 32) % 4 == 0))
                   ? 32'sh10000 : 0;
            1: v = $signed($urandom_range(0, 1 << 18)) - (1 << 17);
            default: v = rand_word();
         endcase
         send_item(rvt_pkg::OP_LOAD, i[5:0], v, $urandom, $urandom, $urandom, rand_gap());
      end
      // unread slots and the upper data bits
      for (int i = 57; i < 64; i++)
         send_item(rvt_pkg::OP_LOAD, i[5:0], $urandom, 0, 0, 0, 0);
   endtask

   task automatic drain();
      while (shade_q.size() != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
   endtask

   task automatic test_identity_extremes();
      logic signed [31:0] ext [5] = '{32'sh7fffffff, 32'sh80000000, 0, 1, -1};
      load_store(0);
      foreach (ext[i])
         send_item(rvt_pkg::OP_VERT, 6'd0, 0, ext[i], ext[(i + 1) % 5], ext[(i + 2) % 5], 0);
      // short vectors that skip normalization, then a unit vector
      send_item(rvt_pkg::OP_VERT, 6'h3f, 32'shffffffff, 0, 0, 0, 0);
      send_item(rvt_pkg::OP_VERT, 6'd0, 0, 3, -2, 1, 0);
      send_item(rvt_pkg::OP_VERT, 6'd0, 0, 32'sh10000, 0, 0, 0);
      end_burst();
      drain();
   endtask

   task automatic test_saturation();
      load_store(2);
      for (int i = 0; i < 10; i++)
         send_item(rvt_pkg::OP_VERT, 6'd0, 0, rand_word(), rand_word(), rand_word(), 0);
      end_burst();
      drain();
   endtask

   task automatic test_backpressure();
      hold_off = 1;
      fork
         begin
            for (int i = 0; i < 200; i++) send_item(rvt_pkg::OP_VERT, 6'($urandom), $urandom,
               rand_word(), rand_word(), rand_word(), 0);
            end_burst();
         end
         begin
            repeat (600) @(negedge clock);
            hold_off = 0;
         end
      join
      drain();
   endtask

   task automatic test_random_stream(input int phases);
      for (int ph = 0; ph < phases; ph++) begin
         rnd_stall = (ph % 3 != 2);
         load_store(ph % 3);
         for (int i = 0; i < 85; i++)
            send_item(rvt_pkg::OP_VERT, 6'($urandom), $urandom, rand_word(), rand_word(),
                      rand_word(), rnd_stall ? rand_gap() : 0);
         end_burst();
         drain();
      end
      rnd_stall = 1;
   endtask

   initial begin
      req_chan.valid = 0; req_chan.op = rvt_pkg::OP_LOAD; req_chan.coef_index = 0;
      req_chan.coef_value = 0; req_chan.vert_x = 0; req_chan.vert_y = 0; req_chan.vert_z = 0;
      foreach (coef_mem[i]) coef_mem[i] = 0;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(negedge clock);
      test_identity_extremes();
      test_saturation();
      load_store(1);
      test_backpressure();
      test_random_stream(3);
      $display("covered %0d vertices and %0d coefficient loads, %0d responses checked",
               vert_cnt, load_cnt, rsp_cnt);
      $display("store sets: identity, small random, full-range; one long response stall");
      if (err_cnt == 0 && shade_q.size() == 0)
         $display("reflection_vertex_transform_unit test passed");
      else
         $display("reflection_vertex_transform_unit test failed");
      $finish;
   end
endmodule
